/* sv/fcpm_pkg.sv */
// fcpm_pkg: shared types and constants of the fan curve pwm mapper
// used by fcpm_div and fan_curve_pwm_mapper; depends on nothing
`timescale 1ns / 1ps

package fcpm_pkg;

    // fixed arithmetic widths of the serial divider
    localparam int DIV_W = 32;
    localparam int DVS_W = 16;

    // percent scale, 1/256 percent units
    localparam logic [15:0] FULL_PERCENT     = 16'd25600;
    localparam logic [15:0] TWO_FULL_PERCENT = 16'd51200;
    localparam logic [14:0] PCT_MAX          = 15'h7FFF;
    localparam logic [7:0]  PWM_MAX          = 8'hFF;

    // pwm scaling divides by TWO_FULL_PERCENT = 25 << 11: a shift by 11, then
    // a multiply by the reciprocal of 25, exact for shifted totals below 2^13
    localparam int          PWM_PRE_SHIFT = 11;
    localparam int          RECIP_SHIFT   = 18;
    localparam logic [13:0] RECIP_25      = 14'd10486;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_NUM_POINTS = 2'd0,
        CFG_MIN_PWM    = 2'd1,
        CFG_MAX_PWM    = 2'd2,
        CFG_ZERO_RPM   = 2'd3
    } t_cfg_reg;

    // divider request and status
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_sts;

endpackage

/* sv/fan_curve_pwm_mapper.sv */
// fan_curve_pwm_mapper: piecewise linear fan curve lookup with pwm scaling
// depends on fcpm_pkg, fcpm_ram (curve point store), fcpm_div (serial divider)
//
//  channel  dir  handshake                   payload
//  s        in   i_s_tvalid / o_s_tready     i_s_tdata (load or sample), i_s_tuser
//  m        out  o_m_tvalid / i_m_tready     o_m_tdata (percent, pwm)
//  cfg      in   i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
//  a load word is written in S_IDLE; a sample word reads and checks the first point,
//  clamping below it, then the last point, clamping above it, and otherwise runs a
//  binary search over the points and interpolates, waiting on the 32-step serial
//  divider; pwm scaling is a shift and a reciprocal multiply, and a zero pwm skips
//  the multiply
//  s is not ready meanwhile, and also while a finished word waits on a full m register
//  reset is synchronous, active low; curve points are undefined until loaded
//  the result sits in an output register, so m stalls block loads only while a finished word waits
`timescale 1ns / 1ps

module fan_curve_pwm_mapper #(
    parameter int MAX_POINTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // point_index[3:0], point_temp[19:4], point_percent[34:20], temperature[50:35]
    input  logic [55:0] i_s_tdata,
    // req_type[0]
    input  logic [0:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // fan_percent_out[14:0], pwm_out[22:15]
    output logic [23:0] o_m_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import fcpm_pkg::*;

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int SW    = CW + 1;
    localparam int RAM_W = 31;
    localparam int PW    = 35;

    typedef enum logic [17:0] {
        S_IDLE     = 18'h00001,
        S_RD_FIRST = 18'h00002,
        S_CK_FIRST = 18'h00004,
        S_RD_LAST  = 18'h00008,
        S_CK_LAST  = 18'h00010,
        S_SRCH_RD  = 18'h00020,
        S_SRCH_CK  = 18'h00040,
        S_RD_HI    = 18'h00080,
        S_CK_HI    = 18'h00100,
        S_CK_LO    = 18'h00200,
        S_IP_MUL   = 18'h00400,
        S_IP_DIV   = 18'h00800,
        S_IP_WAIT  = 18'h01000,
        S_PWM_SET  = 18'h02000,
        S_PWM_MUL  = 18'h04000,
        S_PWM_TOT  = 18'h08000,
        S_PWM_RCP  = 18'h10000,
        S_OUT      = 18'h20000
    } t_state;

    // input word fields
    logic               w_req_sample;
    logic [3:0]         w_point_index;
    logic signed [15:0] w_point_temp;
    logic [14:0]        w_point_percent;
    logic signed [15:0] w_temperature;

    assign w_req_sample    = i_s_tuser[0];
    assign w_point_index   = i_s_tdata[3:0];
    assign w_point_temp    = $signed(i_s_tdata[19:4]);
    assign w_point_percent = i_s_tdata[34:20];
    assign w_temperature   = $signed(i_s_tdata[50:35]);

    // configuration registers
    logic [4:0] r_num_points;
    logic [7:0] r_min_pwm;
    logic [7:0] r_max_pwm;
    logic       r_zero_rpm;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_points <= 5'd2;
            r_min_pwm    <= 8'd0;
            r_max_pwm    <= 8'd255;
            r_zero_rpm   <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_NUM_POINTS: r_num_points <= i_cfg_data[4:0];
                CFG_MIN_PWM:    r_min_pwm    <= i_cfg_data;
                CFG_MAX_PWM:    r_max_pwm    <= i_cfg_data;
                CFG_ZERO_RPM:   r_zero_rpm   <= i_cfg_data[0];
            endcase
        end
    end

    // points in use, clamped to 1..MAX_POINTS
    logic [CW-1:0] w_active;
    logic [AW-1:0] w_last;

    always_comb begin
        if (r_num_points == '0) begin
            w_active = CW'(1);
        end else if (32'(r_num_points) > MAX_POINTS) begin
            w_active = CW'(MAX_POINTS);
        end else begin
            w_active = CW'(r_num_points);
        end
    end

    assign w_last = AW'(w_active - CW'(1));

    // sequencer and datapath registers
    t_state             r_state, n_state;
    logic signed [15:0] r_temp, n_temp;
    logic signed [SW-1:0] r_lo, n_lo;
    logic signed [SW-1:0] r_hi, n_hi;
    logic [AW-1:0]      r_mid, n_mid;
    logic signed [15:0] r_thi, n_thi;
    logic [14:0]        r_phi, n_phi;
    logic [15:0]        r_dt, n_dt;
    logic signed [17:0] r_opa, n_opa;
    logic signed [16:0] r_opb, n_opb;
    logic signed [PW-1:0] r_prod, n_prod;
    logic               r_neg, n_neg;
    logic [14:0]        r_pct, n_pct;
    logic [7:0]         r_pwm, n_pwm;
    logic               r_out_valid, n_out_valid;
    logic [14:0]        r_out_pct, n_out_pct;
    logic [7:0]         r_out_pwm, n_out_pwm;

    // curve store and divider
    logic               w_ram_we;
    logic [AW-1:0]      w_ram_addr;
    logic [RAM_W-1:0]   w_ram_rdata;
    logic signed [15:0] w_rd_temp;
    logic [14:0]        w_rd_pct;
    t_div_req           w_div_req;
    t_div_sts           w_div_sts;

    assign w_rd_temp = $signed(w_ram_rdata[30:15]);
    assign w_rd_pct  = w_ram_rdata[14:0];

    fcpm_ram #(
        .WIDTH(RAM_W),
        .DEPTH(MAX_POINTS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_addr (w_ram_addr),
        .i_wdata({w_point_temp, w_point_percent}),
        .o_rdata(w_ram_rdata)
    );

    fcpm_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_div_req),
        .o_sts  (w_div_sts)
    );

    logic w_s_accept;
    assign o_s_tready = (r_state == S_IDLE);
    assign w_s_accept = i_s_tvalid && o_s_tready;

    // store a load word whose slot exists
    assign w_ram_we = w_s_accept && !w_req_sample && (32'(w_point_index) < MAX_POINTS);

    // binary search midpoint, lo and hi are non-negative inside the loop
    logic [SW:0]   w_mid_sum;
    logic [AW-1:0] w_mid;
    assign w_mid_sum = (SW+1)'(r_lo) + (SW+1)'(r_hi);
    assign w_mid     = AW'(w_mid_sum >> 1);

    // interpolation operands
    logic signed [16:0] w_off;
    logic signed [16:0] w_dt;
    logic signed [15:0] w_dp;
    logic signed [8:0]  w_range;
    assign w_off   = $signed({r_temp[15], r_temp}) - $signed({r_thi[15], r_thi});
    assign w_dt    = $signed({w_rd_temp[15], w_rd_temp}) - $signed({r_thi[15], r_thi});
    assign w_dp    = $signed({1'b0, w_rd_pct}) - $signed({1'b0, r_phi});
    assign w_range = $signed({1'b0, r_max_pwm}) - $signed({1'b0, r_min_pwm});

    // shared multiplier
    logic signed [PW-1:0] w_mul;
    assign w_mul = r_opa * r_opb;

    // signed quotient plus base percent
    logic signed [32:0] w_q;
    logic signed [33:0] w_sum;
    assign w_q   = r_neg ? -$signed({1'b0, w_div_sts.quotient})
                         : $signed({1'b0, w_div_sts.quotient});
    assign w_sum = 34'(w_q) + $signed({19'b0, r_phi});

    // pwm numerator, doubled to round half up
    logic signed [27:0] w_total;
    logic               w_pwm_zero;
    assign w_total = $signed(28'(r_min_pwm) * 28'(TWO_FULL_PERCENT))
                   + $signed({r_prod[26:0], 1'b0})
                   + $signed(28'(FULL_PERCENT));
    assign w_pwm_zero = (r_zero_rpm && r_pct == '0) || (w_total < 0);

    // numerator over 2048, and its quotient by 25 from the reciprocal product
    logic [12:0] w_total_hi;
    logic [8:0]  w_pwm_q;
    assign w_total_hi = w_total[PWM_PRE_SHIFT +: 13];
    assign w_pwm_q    = w_mul[RECIP_SHIFT +: 9];

    // magnitude of the interpolation product
    logic [PW-1:0] w_prod_abs;
    assign w_prod_abs = r_prod[PW-1] ? PW'(-r_prod) : PW'(r_prod);

    // ram address and divider request
    always_comb begin
        w_div_req.start    = 1'b0;
        w_div_req.dividend = w_prod_abs[DIV_W-1:0];
        w_div_req.divisor  = r_dt;
        w_ram_addr         = '0;
        unique case (r_state)
            S_IDLE:    w_ram_addr = AW'(w_point_index);
            S_RD_LAST: w_ram_addr = w_last;
            S_SRCH_RD: w_ram_addr = w_mid;
            S_RD_HI:   w_ram_addr = r_hi[AW-1:0];
            S_CK_HI:   w_ram_addr = r_lo[AW-1:0];
            S_IP_DIV:  w_div_req.start = 1'b1;
            default: w_ram_addr = '0;
        endcase
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_temp      = r_temp;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_thi       = r_thi;
        n_phi       = r_phi;
        n_dt        = r_dt;
        n_opa       = r_opa;
        n_opb       = r_opb;
        n_prod      = r_prod;
        n_neg       = r_neg;
        n_pct       = r_pct;
        n_pwm       = r_pwm;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_pct   = r_out_pct;
        n_out_pwm   = r_out_pwm;
        unique case (r_state)
            S_IDLE: begin
                if (w_s_accept && w_req_sample) begin
                    n_temp  = w_temperature;
                    n_state = S_RD_FIRST;
                end
            end
            S_RD_FIRST: n_state = S_CK_FIRST;
            // clamp below the first point
            S_CK_FIRST: begin
                if (r_temp <= w_rd_temp) begin
                    n_pct   = w_rd_pct;
                    n_state = S_PWM_SET;
                end else begin
                    n_state = S_RD_LAST;
                end
            end
            S_RD_LAST: n_state = S_CK_LAST;
            // clamp above the last point, else start the search
            S_CK_LAST: begin
                if (r_temp >= w_rd_temp) begin
                    n_pct   = w_rd_pct;
                    n_state = S_PWM_SET;
                end else begin
                    n_lo    = '0;
                    n_hi    = $signed(SW'(w_last));
                    n_state = S_SRCH_RD;
                end
            end
            S_SRCH_RD: begin
                if (r_lo <= r_hi) begin
                    n_mid   = w_mid;
                    n_state = S_SRCH_CK;
                end else begin
                    if (r_hi < 0) begin
                        n_hi = '0;
                    end
                    if (r_lo > $signed(SW'(w_last))) begin
                        n_lo = $signed(SW'(w_last));
                    end
                    n_state = S_RD_HI;
                end
            end
            S_SRCH_CK: begin
                if (r_temp == w_rd_temp) begin
                    n_pct   = w_rd_pct;
                    n_state = S_PWM_SET;
                end else begin
                    if (r_temp < w_rd_temp) begin
                        n_hi = $signed(SW'(r_mid)) - $signed(SW'(1));
                    end else begin
                        n_lo = $signed(SW'(r_mid)) + $signed(SW'(1));
                    end
                    n_state = S_SRCH_RD;
                end
            end
            S_RD_HI: n_state = S_CK_HI;
            S_CK_HI: begin
                n_thi   = w_rd_temp;
                n_phi   = w_rd_pct;
                n_state = S_CK_LO;
            end
            // a pair that does not rise gives the lower point
            S_CK_LO: begin
                if (w_dt <= 0) begin
                    n_pct   = r_phi;
                    n_state = S_PWM_SET;
                end else begin
                    n_dt    = w_dt[15:0];
                    n_opa   = 18'(w_off);
                    n_opb   = 17'(w_dp);
                    n_state = S_IP_MUL;
                end
            end
            S_IP_MUL: begin
                n_prod  = w_mul;
                n_state = S_IP_DIV;
            end
            S_IP_DIV: begin
                n_neg   = r_prod[PW-1];
                n_state = S_IP_WAIT;
            end
            S_IP_WAIT: begin
                if (w_div_sts.done) begin
                    if (w_sum < 0) begin
                        n_pct = '0;
                    end else if (w_sum > $signed(34'(PCT_MAX))) begin
                        n_pct = PCT_MAX;
                    end else begin
                        n_pct = w_sum[14:0];
                    end
                    n_state = S_PWM_SET;
                end
            end
            S_PWM_SET: begin
                n_opa   = 18'(w_range);
                n_opb   = $signed({2'b0, r_pct});
                n_state = S_PWM_MUL;
            end
            S_PWM_MUL: begin
                n_prod  = w_mul;
                n_state = S_PWM_TOT;
            end
            // zero rpm or negative total, else set up the divide by 25
            S_PWM_TOT: begin
                if (w_pwm_zero) begin
                    n_pwm   = '0;
                    n_state = S_OUT;
                end else begin
                    n_opa   = $signed({5'b0, w_total_hi});
                    n_opb   = $signed({3'b0, RECIP_25});
                    n_state = S_PWM_RCP;
                end
            end
            S_PWM_RCP: begin
                n_pwm   = (w_pwm_q > 9'(PWM_MAX)) ? PWM_MAX : w_pwm_q[7:0];
                n_state = S_OUT;
            end
            // hand the result word to the output register
            S_OUT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_pct   = r_pct;
                    n_out_pwm   = r_pwm;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_temp    <= n_temp;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_mid     <= n_mid;
        r_thi     <= n_thi;
        r_phi     <= n_phi;
        r_dt      <= n_dt;
        r_opa     <= n_opa;
        r_opb     <= n_opb;
        r_prod    <= n_prod;
        r_neg     <= n_neg;
        r_pct     <= n_pct;
        r_pwm     <= n_pwm;
        r_out_pct <= n_out_pct;
        r_out_pwm <= n_out_pwm;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_pwm, r_out_pct};

    // checks
    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IP_DIV) |-> (r_dt != '0))
        else $error("interpolation divisor is zero");

    a_pair_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD_HI) |-> (r_hi >= 0 && r_lo <= $signed(SW'(w_last))))
        else $error("bracketing pair out of range");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state == S_OUT))
        else $error("result word without a finished sample");

    a_wait_ends_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IP_WAIT) && !w_div_sts.busy) |-> w_div_sts.done)
        else $error("waiting on an idle divider");

endmodule

/* sv/fcpm_ram.sv */
// fcpm_ram: generic single port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module fcpm_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read on one port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/fcpm_div.sv */
// fcpm_div: restoring unsigned divider, one quotient bit per cycle
// depends on fcpm_pkg for widths and the request and status structs
`timescale 1ns / 1ps

module fcpm_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fcpm_pkg::t_div_req i_req,
    output fcpm_pkg::t_div_sts o_sts
);
    import fcpm_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DIV_W-1:0] r_num, n_num;
    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DVS_W-1:0] r_den, n_den;
    logic [DVS_W:0]   w_trial;
    logic             w_ge;

    // one restoring step: shift in next dividend bit, try subtract
    assign w_trial = {r_rem, r_num[DIV_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DIV_W - 1);
            n_num  = i_req.dividend;
            n_rem  = '0;
            n_den  = i_req.divisor;
        end else if (r_busy) begin
            n_num = {r_num[DIV_W-2:0], w_ge};
            n_rem = w_ge ? DVS_W'(w_trial - {1'b0, r_den}) : w_trial[DVS_W-1:0];
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_num <= n_num;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_sts.busy     = r_busy;
    assign o_sts.done     = r_done;
    assign o_sts.quotient = r_num;

    // checks
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");

    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy && r_cnt == '0))
        else $error("divider done without a last step");

    a_busy_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_busy) |-> $past(i_req.start))
        else $error("divider busy without a start");

endmodule

/* bench/fan_curve_pwm_mapper_tb.sv */
`timescale 1ns / 1ps
// fan_curve_pwm_mapper_tb: self-checking bench for the fan curve pwm mapper
// depends on fcpm_pkg and fan_curve_pwm_mapper; a directed table, then random phases
// of loads and samples; results checked against table values or a behavioral lookup

module fan_curve_pwm_mapper_tb;
    import fcpm_pkg::*;

    localparam int N_PTS           = 16;
    localparam int N_DIR           = 20;
    localparam int N_PHASES        = 12;
    localparam int WORDS_PER_PHASE = 160;
    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 200;
    localparam int HOLD_AT_RESULT  = 60;
    localparam int HOLD_CYCLES     = 600;

    typedef enum logic {
        REQ_LOAD   = 1'b0,
        REQ_SAMPLE = 1'b1
    } req_kind_e;

    typedef struct packed {
        logic [14:0] pct;
        logic [7:0]  pwm;
    } fan_result_t;

    // one input word; want is used only where typed is set
    typedef struct packed {
        req_kind_e   kind;
        logic [3:0]  slot;
        logic [15:0] p_temp;
        logic [14:0] p_pct;
        logic [15:0] s_temp;
        logic        typed;
        fan_result_t want;
    } fan_word_t;

    typedef struct packed {
        logic [4:0] np;
        logic [7:0] lo_pwm;
        logic [7:0] hi_pwm;
        logic       zr;
    } cfg_set_t;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    // point_index[3:0], point_temp[19:4], point_percent[34:20], temperature[50:35]
    logic [55:0] i_s_tdata   = '0;
    // req_type[0]
    logic [0:0]  i_s_tuser   = '0;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    // fan_percent_out[14:0], pwm_out[22:15]
    logic [23:0] o_m_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data  = '0;

    // behavioral copy of curve and registers
    logic signed [15:0] curve_t [N_PTS];
    logic [14:0]        curve_p [N_PTS];
    logic [4:0]         np_cfg;
    logic [7:0]         lo_pwm_cfg;
    logic [7:0]         hi_pwm_cfg;
    logic               zr_cfg;

    fan_result_t due_q [$];
    int          mismatches = 0;
    bit          quiet      = 1'b0;
    int          cyc;

    // directed words: ramp curve, extremes, then a descending curve
    fan_word_t dir_tbl [N_DIR] = '{
        '{REQ_LOAD,   4'd0, 16'd400,   15'd0,     16'h1234, 1'b0, '0},
        '{REQ_LOAD,   4'd1, 16'd1280,  15'd25600, 16'hEDCB, 1'b0, '0},
        // clamp below first point and above last point
        '{REQ_SAMPLE, 4'hF, 16'hFFFF,  15'h7FFF,  16'h8000, 1'b1, '{15'd0, 8'd0}},
        '{REQ_SAMPLE, 4'h0, 16'h0000,  15'h0000,  16'h7FFF, 1'b1, '{15'd25600, 8'd255}},
        // exact hits on both points
        '{REQ_SAMPLE, 4'h5, 16'h5A5A,  15'h2A2A,  16'd400,  1'b1, '{15'd0, 8'd0}},
        '{REQ_SAMPLE, 4'hA, 16'hA5A5,  15'h5555,  16'd1280, 1'b1, '{15'd25600, 8'd255}},
        '{REQ_SAMPLE, 4'h3, 16'h0F0F,  15'h0F0F,  16'd840,  1'b0, '0},
        '{REQ_SAMPLE, 4'hC, 16'hF0F0,  15'h7070,  16'd401,  1'b0, '0},
        '{REQ_SAMPLE, 4'h6, 16'h3C3C,  15'h1C1C,  16'd1279, 1'b0, '0},
        // widest span, percent above full scale
        '{REQ_LOAD,   4'd0, 16'h8000,  15'h7FFF,  16'hC3C3, 1'b0, '0},
        '{REQ_LOAD,   4'd1, 16'h7FFF,  15'd0,     16'h3C3C, 1'b0, '0},
        '{REQ_SAMPLE, 4'h9, 16'h6969,  15'h6969,  16'h8000, 1'b1, '{15'h7FFF, 8'd255}},
        '{REQ_SAMPLE, 4'h2, 16'h9696,  15'h1696,  16'h7FFF, 1'b1, '{15'd0, 8'd0}},
        '{REQ_SAMPLE, 4'h7, 16'h0001,  15'h0001,  16'h0000, 1'b0, '0},
        '{REQ_SAMPLE, 4'h8, 16'hFFFE,  15'h7FFE,  16'hFFFF, 1'b0, '0},
        // unsorted curve, temperatures falling
        '{REQ_LOAD,   4'd0, 16'd1600,  15'd25600, 16'h0000, 1'b0, '0},
        '{REQ_LOAD,   4'd1, 16'd320,   15'd0,     16'hFFFF, 1'b0, '0},
        '{REQ_SAMPLE, 4'h4, 16'h4444,  15'h4444,  16'd800,  1'b0, '0},
        '{REQ_SAMPLE, 4'hB, 16'hBBBB,  15'h3BBB,  16'd2000, 1'b0, '0},
        '{REQ_LOAD,   4'd15, 16'hFFFF, 15'h7FFF,  16'h8001, 1'b0, '0}
    };

    // register settings of the first phases, extremes among them
    cfg_set_t cfg_plan [6] = '{
        '{5'd16, 8'd0,   8'd255, 1'b0},
        '{5'd1,  8'd255, 8'd0,   1'b1},
        '{5'd0,  8'd37,  8'd200, 1'b1},
        '{5'd31, 8'd255, 8'd255, 1'b0},
        '{5'd17, 8'd0,   8'd0,   1'b1},
        '{5'd5,  8'd200, 8'd10,  1'b0}
    };

    fan_curve_pwm_mapper #(
        .MAX_POINTS(N_PTS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // points in use, count clamped to 1..N_PTS
    function automatic int active_pts();
        if (np_cfg == 5'd0) return 1;
        if (np_cfg > N_PTS) return N_PTS;
        return int'(np_cfg);
    endfunction

    // clamp, exact hit or binary search, then truncating interpolation
    function automatic logic [14:0] curve_percent(input logic signed [15:0] t);
        int      n;
        int      lo;
        int      hi;
        int      mid;
        longint  dt;
        longint  dp;
        longint  off;
        longint  q;
        n = active_pts();
        if (t <= curve_t[0]) return curve_p[0];
        if (t >= curve_t[n-1]) return curve_p[n-1];
        lo = 0;
        hi = n - 1;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (t == curve_t[mid]) return curve_p[mid];
            if (t < curve_t[mid]) hi = mid - 1;
            else lo = mid + 1;
        end
        if (hi < 0) hi = 0;
        if (lo > n - 1) lo = n - 1;
        dt  = longint'(curve_t[lo]) - longint'(curve_t[hi]);
        dp  = longint'(curve_p[lo]) - longint'(curve_p[hi]);
        off = longint'(t) - longint'(curve_t[hi]);
        if (dt <= 0) return curve_p[hi];
        q = (off * dp) / dt + longint'(curve_p[hi]);
        if (q < 0) q = 0;
        if (q > longint'(PCT_MAX)) q = longint'(PCT_MAX);
        return q[14:0];
    endfunction

    // percent into min..max pwm, round half up, saturate
    function automatic logic [7:0] pwm_scale(input logic [14:0] pct);
        longint span;
        longint total;
        longint v;
        if (zr_cfg && pct == 15'd0) return 8'd0;
        span  = longint'(hi_pwm_cfg) - longint'(lo_pwm_cfg);
        total = 2 * longint'(lo_pwm_cfg) * longint'(FULL_PERCENT)
                + 2 * span * longint'(pct) + longint'(FULL_PERCENT);
        if (total < 0) return 8'd0;
        v = total / longint'(TWO_FULL_PERCENT);
        if (v > longint'(PWM_MAX)) v = longint'(PWM_MAX);
        return v[7:0];
    endfunction

    // offer one word after a random gap; valid stays high when no gap follows
    task automatic send_word(input fan_word_t w);
        int          gap;
        logic [14:0] pct;
        gap = quiet ? 0 : $urandom_range(14);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= w.kind;
        i_s_tdata  <= {5'd0, w.s_temp, w.p_pct, w.p_temp, w.slot};
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        if (w.kind == REQ_LOAD) begin
            curve_t[w.slot] = w.p_temp;
            curve_p[w.slot] = w.p_pct;
        end else if (w.typed) begin
            due_q.push_back(w.want);
        end else begin
            pct = curve_percent(w.s_temp);
            due_q.push_back({pct, pwm_scale(pct)});
        end
    endtask

    // write all four registers back to back, then release the channel
    task automatic write_config(input cfg_set_t c);
        t_cfg_reg   regs [4] = '{CFG_NUM_POINTS, CFG_MIN_PWM, CFG_MAX_PWM, CFG_ZERO_RPM};
        logic [7:0] data;
        int         r;
        for (r = 0; r < 4; r++) begin
            case (regs[r])
                CFG_NUM_POINTS: data = {3'd0, c.np};
                CFG_MIN_PWM:    data = c.lo_pwm;
                CFG_MAX_PWM:    data = c.hi_pwm;
                default:        data = {7'd0, c.zr};
            endcase
            i_cfg_valid <= 1'b1;
            i_cfg_index <= regs[r];
            i_cfg_data  <= data;
            do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        end
        i_cfg_valid <= 1'b0;
        np_cfg     = c.np;
        lo_pwm_cfg = c.lo_pwm;
        hi_pwm_cfg = c.hi_pwm;
        zr_cfg     = c.zr;
    endtask

    // wait for every expected word, then let the block go quiet
    task automatic settle(input int cycles);
        while (due_q.size() != 0) @(posedge i_clk);
        repeat (cycles) @(posedge i_clk);
    endtask

    // run limit
    initial begin : watchdog
        for (cyc = 0; cyc < CYCLE_LIMIT; cyc++) @(posedge i_clk);
        $display("Test completed with failures");
        $finish;
    end

    // result side: random stalls, one long hold-off, field checks
    initial begin : result_sink
        int          gap;
        int          got;
        fan_result_t want;
        got = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = (got == HOLD_AT_RESULT) ? HOLD_CYCLES : (quiet ? 0 : $urandom_range(14));
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (o_m_tvalid !== 1'b1);
            got++;
            if (due_q.size() == 0) begin
                $display("%0t: result word %h with none expected", $time, o_m_tdata);
                mismatches++;
            end else begin
                want = due_q.pop_front();
                if (o_m_tdata[14:0] !== want.pct) begin
                    $display("%0t: fan percent expected %0d, got %0d",
                             $time, want.pct, o_m_tdata[14:0]);
                    mismatches++;
                end
                if (o_m_tdata[22:15] !== want.pwm) begin
                    $display("%0t: pwm expected %0d, got %0d",
                             $time, want.pwm, o_m_tdata[22:15]);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        fan_word_t w;
        cfg_set_t  c;
        int        ph;
        int        k;
        int        n;
        int        roll;
        int        lo_b;
        int        hi_b;
        int        acc;
        int        spread;
        np_cfg     = 5'd2;
        lo_pwm_cfg = 8'd0;
        hi_pwm_cfg = 8'd255;
        zr_cfg     = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table at reset settings
        for (k = 0; k < N_DIR; k++) send_word(dir_tbl[k]);
        i_s_tvalid <= 1'b0;

        for (ph = 1; ph <= N_PHASES; ph++) begin
            settle(SETTLE_CYCLES);
            if (ph <= 6) begin
                c = cfg_plan[ph-1];
            end else begin
                c.np     = ($urandom_range(3) == 0) ? 5'($urandom_range(31))
                                                    : 5'($urandom_range(16, 2));
                c.lo_pwm = 8'($urandom);
                c.hi_pwm = 8'($urandom);
                c.zr     = 1'($urandom);
            end
            write_config(c);
            quiet = (ph % 3 == 2);

            // fresh rising curve over all slots
            spread = ($urandom_range(3) == 0) ? 4369 : $urandom_range(1500, 16);
            acc    = ($urandom_range(3) == 0) ? -32768 : $urandom_range(30000) - 32768;
            for (k = 0; k < N_PTS; k++) begin
                w        = '0;
                w.kind   = REQ_LOAD;
                w.slot   = 4'(k);
                w.p_temp = (acc > 32767) ? 16'h7FFF : 16'(acc);
                w.s_temp = 16'($urandom);
                case ($urandom_range(7))
                    0:       w.p_pct = 15'd0;
                    1:       w.p_pct = 15'($urandom_range(32767));
                    2:       w.p_pct = 15'd25600;
                    default: w.p_pct = 15'($urandom_range(25600));
                endcase
                send_word(w);
                acc = acc + $urandom_range(spread);
            end

            // mixed samples and reloads
            for (k = N_PTS; k < WORDS_PER_PHASE; k++) begin
                w.typed  = 1'b0;
                w.slot   = 4'($urandom);
                w.p_temp = 16'($urandom);
                w.p_pct  = 15'($urandom);
                w.s_temp = 16'($urandom);
                n        = active_pts();
                roll     = $urandom_range(99);
                if (roll < 65) begin
                    w.kind = REQ_SAMPLE;
                    case ($urandom_range(9))
                        0, 1, 2, 3, 4: begin
                            lo_b = int'(curve_t[0]);
                            hi_b = int'(curve_t[n-1]);
                            if (hi_b >= lo_b)
                                w.s_temp = 16'(lo_b + int'($urandom_range(hi_b - lo_b)));
                        end
                        5, 6:    w.s_temp = curve_t[$urandom_range(n - 1)];
                        7:       w.s_temp = $urandom_range(1) ? 16'h7FFF : 16'h8000;
                        default: ;
                    endcase
                end else begin
                    w.kind = REQ_LOAD;
                    // mostly keep the curve sorted, sometimes break it
                    if (roll < 90) begin
                        lo_b = (w.slot == 4'd0)  ? -32768 : int'(curve_t[w.slot - 4'd1]);
                        hi_b = (w.slot == 4'd15) ? 32767  : int'(curve_t[w.slot + 4'd1]);
                        if (hi_b >= lo_b)
                            w.p_temp = 16'(lo_b + int'($urandom_range(hi_b - lo_b)));
                    end
                    if ($urandom_range(7) != 0) w.p_pct = 15'($urandom_range(25600));
                end
                send_word(w);
            end
            i_s_tvalid <= 1'b0;
        end

        settle(DRAIN_CYCLES);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
